>>> hdl/dvr_pkg.sv
// Shared types, codes and constants of the distance-vector route table.
`default_nettype none

package dvr_pkg;

  // Fixed field widths.
  localparam int MODE_W     = 2;
  localparam int PORT_W     = 2;
  localparam int DEST_W     = 6;
  localparam int COST_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Table geometry and neighbor count.
  localparam int DVR_NODES  = 64;
  localparam int DVR_PORTS  = 4;

  // Depth of the queues between the front end, back end and result port.
  localparam int DVR_QDEPTH = 2;

  // Cost value that stands for an unreachable destination.
  localparam logic [COST_W-1:0] COST_INF = '1;

  // Item modes on the input port.
  localparam logic [MODE_W-1:0] MODE_ADV    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UP     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOWN   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINK_LAST  = 3'd4;

  // Operations handed from the front end to the back end.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_ABSENT = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
  localparam logic [OP_W-1:0] OP_ADV    = 3'd2;
  localparam logic [OP_W-1:0] OP_UP     = 3'd3;
  localparam logic [OP_W-1:0] OP_DOWN   = 3'd4;

  // Classified item waiting for the table update.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [PORT_W-1:0] port;
    logic [DEST_W-1:0] dest;
    logic [COST_W-1:0] cost;
  } dvr_item_t;

  // One table entry as stored in the RAM.
  typedef struct packed {
    logic              valid;
    logic [PORT_W-1:0] port;
    logic [COST_W-1:0] cost;
  } dvr_entry_t;

  // One result item.
  typedef struct packed {
    logic [PORT_W-1:0] next_hop_port;
    logic              route_usable;
    logic [COST_W-1:0] route_cost;
    logic              table_changed;
  } dvr_result_t;

endpackage

`default_nettype wire

>>> hdl/dvr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module dvr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [AW-1:0]            raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hdl/dvr_fifo.sv
// Small first-in first-out queue of registers.
`default_nettype none

module dvr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_r];

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage for queued items.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dvr_front.sv
// Front end: configuration registers and classification of incoming items.
`default_nettype none

module dvr_front
  import dvr_pkg::*;
#(
  parameter int NODES = DVR_NODES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [MODE_W-1:0]     mode,
  input  wire logic [PORT_W-1:0]     neighbor_port,
  input  wire logic [DEST_W-1:0]     destination,
  input  wire logic [COST_W-1:0]     cost,
  output dvr_item_t                  item
);

  localparam logic [PORT_W:0] PORT_LIM = (PORT_W + 1)'(DVR_PORTS);

  logic [DEST_W-1:0] own_id_r, own_id_nxt;
  logic [COST_W-1:0] link_cost_r [DVR_PORTS];
  logic [COST_W-1:0] link_cost_nxt [DVR_PORTS];
  logic [PORT_W-1:0] link_sel;
  logic [COST_W-1:0] link;
  logic [COST_W:0]   sum;
  logic [COST_W-1:0] adv_cost;
  logic              port_ok;
  logic              dest_ok;

  assign cfg_ready = 1'b1;
  assign link_sel  = PORT_W'(cfg_index - CFG_LINK_FIRST);

  // Register writes.
  always_comb begin
    own_id_nxt    = own_id_r;
    link_cost_nxt = link_cost_r;
    if (cfg_valid) begin
      unique case (cfg_index) inside
        CFG_OWN_ID: begin
          own_id_nxt = cfg_data[DEST_W-1:0];
        end
        [CFG_LINK_FIRST:CFG_LINK_LAST]: begin
          link_cost_nxt[link_sel] = cfg_data[COST_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r <= '0;
      for (int i = 0; i < DVR_PORTS; i++) begin
        link_cost_r[i] <= COST_W'(1);
      end
    end else begin
      own_id_r    <= own_id_nxt;
      link_cost_r <= link_cost_nxt;
    end
  end

  // Advertised cost plus link cost, saturating at infinity.
  assign link     = link_cost_r[neighbor_port];
  assign sum      = {1'b0, cost} + {1'b0, link};
  assign adv_cost = sum[COST_W] ? COST_INF : sum[COST_W-1:0];
  assign port_ok  = ({1'b0, neighbor_port} < PORT_LIM);
  assign dest_ok  = (int'(destination) < NODES);

  // Turn the item into the table operation it calls for.
  always_comb begin
    item.port = neighbor_port;
    item.dest = destination;
    item.cost = adv_cost;
    item.op   = OP_LOOKUP;
    unique case (mode)
      MODE_ADV: begin
        item.op = (port_ok && (destination != own_id_r)) ? OP_ADV : OP_LOOKUP;
      end
      MODE_UP: begin
        item.op   = port_ok ? OP_UP : OP_LOOKUP;
        item.cost = link;
      end
      MODE_DOWN: begin
        item.op = OP_DOWN;
      end
      MODE_LOOKUP: begin
        item.op = OP_LOOKUP;
      end
      default: begin
        item.op = OP_LOOKUP;
      end
    endcase
    if (!dest_ok) begin
      item.op = OP_ABSENT;
    end
  end

endmodule

`default_nettype wire

>>> hdl/dvr_back.sv
// Back end: read-modify-write of one route table entry per item.
`default_nettype none

module dvr_back
  import dvr_pkg::*;
#(
  parameter int NODES = DVR_NODES
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic item_empty,
  output logic      item_pop,
  input  wire dvr_item_t item,
  input  wire logic res_full,
  output logic      res_push,
  output dvr_result_t res,
  output logic      clearing
);

  localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int EW = (AW > DEST_W) ? AW : DEST_W;
  localparam int EWIDTH = $bits(dvr_entry_t);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic              st_r, st_nxt;
  logic              clr_r, clr_nxt;
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  dvr_item_t         cur_r, cur_nxt;

  logic [EW-1:0]     item_ext, cur_ext;
  logic [AW-1:0]     item_addr, cur_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EWIDTH-1:0] ram_wdata;
  logic [EWIDTH-1:0] ram_rdata;
  dvr_entry_t        old_e, new_e;
  logic              chg;

  assign item_ext  = EW'(item.dest);
  assign cur_ext   = EW'(cur_r.dest);
  assign item_addr = item_ext[AW-1:0];
  assign cur_addr  = cur_ext[AW-1:0];
  assign clearing  = clr_r;
  assign old_e     = dvr_entry_t'(ram_rdata);

  dvr_ram #(
    .WIDTH (EWIDTH),
    .DEPTH (NODES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (item_addr),
    .rdata (ram_rdata)
  );

  // Entry update for the item in the execute cycle.
  always_comb begin
    new_e = old_e;
    chg   = 1'b0;
    case (cur_r.op)
      OP_ADV: begin
        if (!old_e.valid || (cur_r.cost < old_e.cost)) begin
          new_e.valid = 1'b1;
          new_e.port  = cur_r.port;
          new_e.cost  = cur_r.cost;
          chg         = 1'b1;
        end
      end
      OP_UP: begin
        chg = !old_e.valid || (old_e.cost != cur_r.cost) || (old_e.port != cur_r.port);
        new_e.valid = 1'b1;
        new_e.port  = cur_r.port;
        new_e.cost  = cur_r.cost;
      end
      OP_DOWN: begin
        if (old_e.valid && (old_e.cost != COST_INF)) begin
          new_e.cost = COST_INF;
          chg        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Item result: the updated entry, or no route if it is invalid or absent.
  always_comb begin
    res.table_changed = chg;
    if (new_e.valid && (cur_r.op != OP_ABSENT)) begin
      res.next_hop_port = new_e.port;
      res.route_usable  = (new_e.cost != COST_INF);
      res.route_cost    = new_e.cost;
    end else begin
      res.next_hop_port = '0;
      res.route_usable  = 1'b0;
      res.route_cost    = COST_INF;
    end
  end

  // Sequencer: clearing pass after reset, then read cycle and execute cycle.
  always_comb begin
    st_nxt       = st_r;
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    cur_nxt      = cur_r;
    item_pop     = 1'b0;
    res_push     = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = cur_addr;
    ram_wdata    = EWIDTH'(new_e);
    if (clr_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
      if (clr_addr_r == AW'(NODES - 1)) begin
        clr_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (!item_empty && !res_full) begin
            item_pop = 1'b1;
            cur_nxt  = item;
            st_nxt   = ST_EXEC;
          end
        end
        ST_EXEC: begin
          ram_we   = chg;
          res_push = 1'b1;
          st_nxt   = ST_IDLE;
        end
        default: begin
          st_nxt = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      st_r       <= st_nxt;
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Item held for its execute cycle.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/distance_vector_route_table.sv
// Top level of the distance-vector route table.
//
//   Channel   Handshake              Payload
//   input     push / full            in_mode, in_neighbor_port, in_destination, in_cost
//   result    empty / pop            out_next_hop_port, out_route_usable,
//                                    out_route_cost, out_table_changed
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// In the back end each item first has its table entry read from the RAM, then updated
// and, if changed, written back; the back end takes no new item until it is through
// with the last one, as the single RAM port pair serves both steps. After reset a
// clearing pass writes every table entry (NODES, 64 by default) while full stays high.
// Queues on both sides of the back end let input and result sides stall independently.
`default_nettype none

module distance_vector_route_table
  import dvr_pkg::*;
#(
  parameter int NODES = DVR_NODES
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [MODE_W-1:0]     in_mode,
  input  wire logic [PORT_W-1:0]     in_neighbor_port,
  input  wire logic [DEST_W-1:0]     in_destination,
  input  wire logic [COST_W-1:0]     in_cost,
  output logic                       empty,
  input  wire logic                  pop,
  output logic      [PORT_W-1:0]     out_next_hop_port,
  output logic                       out_route_usable,
  output logic      [COST_W-1:0]     out_route_cost,
  output logic                       out_table_changed,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = $bits(dvr_item_t);
  localparam int RW = $bits(dvr_result_t);

  dvr_item_t   front_item;
  logic        mid_full, mid_empty, mid_pop;
  logic [IW-1:0] mid_dout;
  logic        res_full, res_push;
  dvr_result_t back_res;
  logic [RW-1:0] res_dout;
  dvr_result_t out_res;
  logic        clearing;

  // Input side is held off while the table is being cleared.
  assign full = mid_full || clearing;

  dvr_front #(
    .NODES (NODES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (in_mode),
    .neighbor_port (in_neighbor_port),
    .destination   (in_destination),
    .cost          (in_cost),
    .item          (front_item)
  );

  // Queue of classified items between front end and back end.
  dvr_fifo #(
    .WIDTH (IW),
    .DEPTH (DVR_QDEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push && !clearing),
    .din   (IW'(front_item)),
    .full  (mid_full),
    .pop   (mid_pop),
    .dout  (mid_dout),
    .empty (mid_empty)
  );

  dvr_back #(
    .NODES (NODES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_empty (mid_empty),
    .item_pop   (mid_pop),
    .item       (dvr_item_t'(mid_dout)),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (back_res),
    .clearing   (clearing)
  );

  // Result queue feeding the output ports.
  dvr_fifo #(
    .WIDTH (RW),
    .DEPTH (DVR_QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (RW'(back_res)),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign out_res           = dvr_result_t'(res_dout);
  assign out_next_hop_port = out_res.next_hop_port;
  assign out_route_usable  = out_res.route_usable;
  assign out_route_cost    = out_res.route_cost;
  assign out_table_changed = out_res.table_changed;

endmodule

`default_nettype wire
